// ===== src/nfa_pkg.sv =====
package nfa_pkg;

    localparam int STATES      = 16;
    localparam int SYMBOLS     = 16;
    localparam int ST_W        = $clog2(STATES);
    localparam int SY_W        = $clog2(SYMBOLS);
    localparam int CNT_W       = 5;
    localparam int TABLE_DEPTH = STATES * SYMBOLS;
    localparam int ADDR_W      = ST_W + SY_W;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_BEGIN = 2'd1;
    localparam logic [1:0] MODE_STEP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_STATE_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_STATES  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_STATES = 2'd3;

    typedef struct packed {
        logic [1:0]      mode;
        logic [ST_W-1:0] from_state;
        logic [SY_W-1:0] symbol;
        logic [ST_W-1:0] to_state;
    } t_item;

    typedef struct packed {
        logic              accepted;
        logic              dead;
        logic              error;
        logic [STATES-1:0] active_states;
    } t_res;

    typedef struct packed {
        logic [CNT_W-1:0]  state_count;
        logic [CNT_W-1:0]  alphabet_size;
        logic [STATES-1:0] start_states;
        logic [STATES-1:0] accept_states;
    } t_cfg;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_BEGIN  = 3'd1,
        OP_STEP   = 3'd2,
        OP_KILL   = 3'd3,
        OP_REPORT = 3'd4
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [ST_W-1:0] from_state;
        logic [SY_W-1:0] symbol;
        logic [ST_W-1:0] to_state;
    } t_cmd;

    function automatic logic [CNT_W-1:0] used_count(input logic [CNT_W-1:0] cnt,
                                                    input logic [CNT_W-1:0] lim);
        return (cnt > lim) ? lim : cnt;
    endfunction

    function automatic logic [STATES-1:0] valid_mask(input logic [CNT_W-1:0] ns);
        logic [STATES-1:0] m;
        for (int i = 0; i < STATES; i++) begin
            m[i] = (CNT_W'(i) < ns);
        end
        return m;
    endfunction

endpackage

// ===== src/nfa_front.sv =====
module nfa_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  nfa_pkg::t_item i_item,
    input  nfa_pkg::t_cfg i_cfg,
    input  logic          i_q_full,
    output logic          o_full,
    output logic          o_q_push,
    output nfa_pkg::t_cmd o_q_cmd
);
    import nfa_pkg::*;

    logic             r_valid;
    logic             n_valid;
    t_cmd             r_cmd;
    t_cmd             n_cmd;
    t_cmd             cls;
    logic [CNT_W-1:0] ns;
    logic [CNT_W-1:0] na;
    logic             bad_from;
    logic             bad_to;
    logic             bad_sym;

    assign ns       = used_count(i_cfg.state_count, CNT_W'(STATES));
    assign na       = used_count(i_cfg.alphabet_size, CNT_W'(SYMBOLS));
    assign bad_from = !({1'b0, i_item.from_state} < ns);
    assign bad_to   = !({1'b0, i_item.to_state} < ns);
    assign bad_sym  = !({1'b0, i_item.symbol} < na);

    always_comb begin
        cls.from_state = i_item.from_state;
        cls.symbol     = i_item.symbol;
        cls.to_state   = i_item.to_state;
        unique case (i_item.mode)
            MODE_LOAD: begin
                cls.op = (bad_from || bad_to || bad_sym) ? OP_REPORT : OP_LOAD;
            end
            MODE_BEGIN: begin
                cls.op = OP_BEGIN;
            end
            MODE_STEP: begin
                cls.op = bad_sym ? OP_KILL : OP_STEP;
            end
            default: begin
                cls.op = OP_REPORT;
            end
        endcase
    end

    assign o_full   = r_valid && i_q_full;
    assign o_q_push = r_valid && !i_q_full;
    assign o_q_cmd  = r_cmd;

    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (i_push && !o_full) begin
            n_valid = 1'b1;
            n_cmd   = cls;
        end else if (o_q_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

endmodule

// ===== src/nfa_cmd_fifo.sv =====
module nfa_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  nfa_pkg::t_cmd i_data,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output nfa_pkg::t_cmd o_data
);
    import nfa_pkg::*;

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] n_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW-1:0] n_rd_ptr;
    logic [FIFO_AW:0]   r_count;
    logic [FIFO_AW:0]   n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= (FIFO_AW+1)'(FIFO_DEPTH)))
        else $error("command queue count beyond depth");

endmodule

// ===== src/nfa_back.sv =====
module nfa_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  nfa_pkg::t_cfg i_cfg,
    input  logic          i_q_empty,
    input  nfa_pkg::t_cmd i_q_cmd,
    output logic          o_q_pop,
    output logic          o_clearing,
    input  logic          i_pop,
    output logic          o_empty,
    output nfa_pkg::t_res o_res
);
    import nfa_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR    = 5'b00001,
        S_IDLE     = 5'b00010,
        S_LOAD     = 5'b00100,
        S_STEP     = 5'b01000,
        S_STEP_END = 5'b10000
    } t_state;

    logic [STATES-1:0] r_table [TABLE_DEPTH];
    logic [STATES-1:0] r_rd_data;

    t_state            r_state;
    t_state            n_state;
    logic [STATES-1:0] r_active;
    logic [STATES-1:0] n_active;
    logic [ST_W-1:0]   r_idx;
    logic [ST_W-1:0]   n_idx;
    logic [SY_W-1:0]   r_sym;
    logic [SY_W-1:0]   n_sym;
    logic [ADDR_W-1:0] r_ld_addr;
    logic [ADDR_W-1:0] n_ld_addr;
    logic [STATES-1:0] r_ld_bit;
    logic [STATES-1:0] n_ld_bit;
    logic [STATES-1:0] r_acc;
    logic [STATES-1:0] n_acc;
    logic              r_take;
    logic              n_take;
    logic [ADDR_W-1:0] r_clr_idx;
    logic [ADDR_W-1:0] n_clr_idx;
    logic              r_out_valid;
    logic              n_out_valid;
    t_res              r_out;
    t_res              n_out;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [STATES-1:0] mem_wd;
    logic [ADDR_W-1:0] mem_ra;
    logic              out_free;
    logic              fin;
    logic              fin_err;
    logic [STATES-1:0] fin_set;
    logic [STATES-1:0] took;
    logic [CNT_W-1:0]  ns;
    logic [STATES-1:0] vmask;

    assign ns         = used_count(i_cfg.state_count, CNT_W'(STATES));
    assign vmask      = valid_mask(ns);
    assign out_free   = !r_out_valid || i_pop;
    assign took       = r_take ? r_rd_data : '0;
    assign o_clearing = (r_state == S_CLEAR);
    assign o_empty    = !r_out_valid;
    assign o_res      = r_out;

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_idx       = r_idx;
        n_sym       = r_sym;
        n_ld_addr   = r_ld_addr;
        n_ld_bit    = r_ld_bit;
        n_acc       = r_acc;
        n_clr_idx   = r_clr_idx;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        n_take      = r_active[r_idx] && ({1'b0, r_idx} < ns);
        mem_we      = 1'b0;
        mem_wa      = r_clr_idx;
        mem_wd      = '0;
        mem_ra      = {r_idx, r_sym};
        o_q_pop     = 1'b0;
        fin         = 1'b0;
        fin_err     = 1'b0;
        fin_set     = r_active;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q_empty && out_free) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_cmd.op)
                        OP_LOAD: begin
                            mem_ra    = {i_q_cmd.from_state, i_q_cmd.symbol};
                            n_ld_addr = {i_q_cmd.from_state, i_q_cmd.symbol};
                            n_ld_bit  = STATES'(1) << i_q_cmd.to_state;
                            n_state   = S_LOAD;
                        end
                        OP_BEGIN: begin
                            n_active = i_cfg.start_states & vmask;
                            fin      = 1'b1;
                            fin_set  = i_cfg.start_states & vmask;
                        end
                        OP_STEP: begin
                            n_sym   = i_q_cmd.symbol;
                            n_idx   = '0;
                            n_acc   = '0;
                            n_state = S_STEP;
                        end
                        OP_KILL: begin
                            n_active = '0;
                            fin      = 1'b1;
                            fin_set  = '0;
                            fin_err  = 1'b1;
                        end
                        default: begin
                            fin     = 1'b1;
                            fin_err = 1'b1;
                        end
                    endcase
                end
            end
            S_LOAD: begin
                mem_we  = 1'b1;
                mem_wa  = r_ld_addr;
                mem_wd  = r_rd_data | r_ld_bit;
                fin     = 1'b1;
                n_state = S_IDLE;
            end
            S_STEP: begin
                // previous state's successor word arrives in the cycle after its read
                if (r_idx != '0) begin
                    n_acc = r_acc | took;
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == '1) begin
                    n_state = S_STEP_END;
                end
            end
            S_STEP_END: begin
                n_active = (r_acc | took) & vmask;
                fin      = 1'b1;
                fin_set  = (r_acc | took) & vmask;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_out_valid         = 1'b1;
            n_out.accepted      = |(fin_set & i_cfg.accept_states);
            n_out.dead          = (fin_set == '0);
            n_out.error         = fin_err;
            n_out.active_states = fin_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_table[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_active    <= '0;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
        end
        r_idx     <= n_idx;
        r_sym     <= n_sym;
        r_ld_addr <= n_ld_addr;
        r_ld_bit  <= n_ld_bit;
        r_acc     <= n_acc;
        r_take    <= n_take;
        r_out     <= n_out;
    end

    a_clear_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("result present during table clear");

    a_dead_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.dead == (r_out.active_states == '0)))
        else $error("dead flag disagrees with active set");

    a_step_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_STEP_END) || (r_state == S_LOAD)) |-> !r_out_valid)
        else $error("result slot occupied when command completes");

endmodule

// ===== src/nfa_acceptance_engine.sv =====
// NFA recognizer: load transitions (mode 0), begin a string (mode 1), then feed symbols
// (mode 2); every item returns one result beat with accepted, dead, error and the active
// set. After reset the transition table is cleared one word per cycle, and full stays
// high until that is done. A symbol step sweeps the 16 states through the single read
// port of the table, one successor word per cycle. A load is a read-modify-write of
// one word; begin and error items complete in the idle state.
// Items are classified on entry and held in a 4-deep command queue plus one entry
// register; the back end starts a command only when the result register is free or
// being popped in the same cycle. Write configuration only while the block is idle.
module nfa_acceptance_engine (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  nfa_pkg::t_item                     i_item,
    output logic                               empty,
    input  logic                               pop,
    output nfa_pkg::t_res                      o_res,
    input  logic                               i_cfg_we,
    input  logic [nfa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [nfa_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import nfa_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic front_full;
    logic clearing;
    logic q_push;
    t_cmd q_in;
    logic q_full;
    logic q_empty;
    logic q_pop;
    t_cmd q_out;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STATE_COUNT:   n_cfg.state_count   = i_cfg_data[CNT_W-1:0];
                CFG_ALPHABET_SIZE: n_cfg.alphabet_size = i_cfg_data[CNT_W-1:0];
                CFG_START_STATES:  n_cfg.start_states  = i_cfg_data[STATES-1:0];
                CFG_ACCEPT_STATES: n_cfg.accept_states = i_cfg_data[STATES-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.state_count   <= CNT_W'(STATES);
            r_cfg.alphabet_size <= CNT_W'(SYMBOLS);
            r_cfg.start_states  <= STATES'(1);
            r_cfg.accept_states <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // hold off new beats until the table clear has finished
    assign full = front_full || clearing;

    nfa_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push && !clearing),
        .i_item   (i_item),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_full   (front_full),
        .o_q_push (q_push),
        .o_q_cmd  (q_in)
    );

    nfa_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    nfa_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_empty  (q_empty),
        .i_q_cmd    (q_out),
        .o_q_pop    (q_pop),
        .o_clearing (clearing),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_res      (o_res)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import nfa_pkg::*;

    localparam logic [1:0] MODE_UNKNOWN = 2'd3;
    localparam int ITEM_W       = $bits(t_item);
    localparam int SETTLE       = 4;
    localparam int TAIL         = 40;
    localparam int LIMIT_CYCLES = 400000;

    class nfa_scoreboard;
        logic [STATES-1:0] succ [STATES][SYMBOLS];
        logic [STATES-1:0] live;
        logic [CNT_W-1:0]  n_states;
        logic [CNT_W-1:0]  n_symbols;
        logic [STATES-1:0] start_mask;
        logic [STATES-1:0] accept_mask;
        t_res              expected_q[$];
        int                fail_count;

        function new();
            foreach (succ[s, y]) succ[s][y] = '0;
            live        = '0;
            n_states    = 5'd16;
            n_symbols   = 5'd16;
            start_mask  = 16'h0001;
            accept_mask = 16'h0000;
            fail_count  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_STATE_COUNT:   n_states    = data[CNT_W-1:0];
                CFG_ALPHABET_SIZE: n_symbols   = data[CNT_W-1:0];
                CFG_START_STATES:  start_mask  = data;
                CFG_ACCEPT_STATES: accept_mask = data;
                default: ;
            endcase
        endfunction

        function void note_item(t_item it);
            int                ns;
            int                na;
            logic [STATES-1:0] in_use;
            logic [STATES-1:0] nxt;
            logic              err;
            t_res              r;
            ns  = (n_states > STATES) ? STATES : int'(n_states);
            na  = (n_symbols > SYMBOLS) ? SYMBOLS : int'(n_symbols);
            err = 1'b0;
            for (int i = 0; i < STATES; i++) in_use[i] = (i < ns);
            case (it.mode)
                MODE_LOAD: begin
                    if (it.from_state >= ns || it.to_state >= ns || it.symbol >= na)
                        err = 1'b1;
                    else
                        succ[it.from_state][it.symbol][it.to_state] = 1'b1;
                end
                MODE_BEGIN: live = start_mask & in_use;
                MODE_STEP: begin
                    if (it.symbol >= na) begin
                        err  = 1'b1;
                        live = '0;
                    end else begin
                        nxt = '0;
                        for (int s = 0; s < ns; s++)
                            if (live[s]) nxt |= succ[s][it.symbol];
                        live = nxt & in_use;
                    end
                end
                default: err = 1'b1;
            endcase
            r.accepted      = |(live & accept_mask);
            r.dead          = (live == '0);
            r.error         = err;
            r.active_states = live;
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void compare(string field, logic [STATES-1:0] exp, logic [STATES-1:0] got);
            if (got !== exp) begin
                $display("%0t: %s expected %h got %h", $time, field, exp, got);
                fail_count++;
            end
        endfunction

        function void check_result(t_res got);
            t_res exp;
            if (expected_q.size() == 0) begin
                $display("%0t: result beat with nothing outstanding, got %h", $time, got);
                fail_count++;
                return;
            end
            exp = expected_q.pop_front();
            compare("accepted", 16'(exp.accepted), 16'(got.accepted));
            compare("dead", 16'(exp.dead), 16'(got.dead));
            compare("error", 16'(exp.error), 16'(got.error));
            compare("active_states", exp.active_states, got.active_states);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  push       = 1'b0;
    logic                  full;
    t_item                 i_item     = '0;
    logic                  empty;
    logic                  pop        = 1'b0;
    t_res                  o_res;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    nfa_scoreboard sb = new();
    bit            tx_steady = 1'b0;
    bit            rx_steady = 1'b0;
    int            rx_hold   = 0;

    nfa_acceptance_engine DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [3:0] pick_below(int n);
        return (n > 0) ? 4'($urandom_range(0, n - 1)) : 4'($urandom);
    endfunction

    function automatic t_item mk(logic [1:0] mode, logic [3:0] from_s, logic [3:0] sym,
                                 logic [3:0] to_s);
        t_item it;
        it.mode       = mode;
        it.from_state = from_s;
        it.symbol     = sym;
        it.to_state   = to_s;
        return it;
    endfunction

    // result side: take beats, stall at random
    always @(posedge i_clk) begin
        if (pop && !empty) begin
            sb.check_result(o_res);
            if ($urandom_range(0, 49) == 0) rx_steady = !rx_steady;
            rx_hold = rx_steady ? 0 : idle_len();
        end else if (rx_hold > 0) begin
            rx_hold--;
        end
        pop <= i_rst_n && (rx_hold == 0);
    end

    task automatic send_item(input t_item it);
        int gap;
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full !== 1'b0) @(posedge i_clk);
        sb.note_item(it);
        gap = tx_steady ? 0 : idle_len();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // junk in the unused upper bits of the count registers
    task automatic set_config(input logic [4:0] sc, input logic [4:0] asz,
                              input logic [15:0] st, input logic [15:0] ac);
        write_reg(CFG_STATE_COUNT, {11'($urandom), sc});
        write_reg(CFG_ALPHABET_SIZE, {11'($urandom), asz});
        write_reg(CFG_START_STATES, st);
        write_reg(CFG_ACCEPT_STATES, ac);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_directed();
        send_item(mk(MODE_BEGIN, 4'd0, 4'd0, 4'd0));
        drain_results();
        // start bits 4 and 15 lie beyond the state count and get dropped
        set_config(5'd4, 5'd3, 16'h8013, 16'h0004);
        send_item(mk(MODE_LOAD, 4'd0, 4'd0, 4'd1));
        send_item(mk(MODE_LOAD, 4'd1, 4'd0, 4'd2));
        send_item(mk(MODE_LOAD, 4'd0, 4'd1, 4'd0));
        send_item(mk(MODE_LOAD, 4'd3, 4'd2, 4'd3));
        send_item(mk(MODE_LOAD, 4'd2, 4'd2, 4'd0));
        send_item(mk(MODE_LOAD, 4'd4, 4'd0, 4'd0));
        send_item(mk(MODE_LOAD, 4'd0, 4'd0, 4'd15));
        send_item(mk(MODE_LOAD, 4'd0, 4'd3, 4'd1));
        send_item(mk(MODE_LOAD, 4'd15, 4'd15, 4'd15));
        send_item(mk(MODE_BEGIN, 4'd0, 4'd0, 4'd0));
        send_item(mk(MODE_STEP, 4'd0, 4'd0, 4'd0));
        send_item(mk(MODE_STEP, 4'd0, 4'd2, 4'd0));
        send_item(mk(MODE_STEP, 4'd0, 4'd1, 4'd0));
        send_item(mk(MODE_STEP, 4'd0, 4'd0, 4'd0));
        send_item(mk(MODE_STEP, 4'd0, 4'd0, 4'd0));
        send_item(mk(MODE_STEP, 4'd0, 4'd1, 4'd0));
        send_item(mk(MODE_STEP, 4'd15, 4'd15, 4'd15));
        send_item(mk(MODE_UNKNOWN, 4'd0, 4'd0, 4'd0));
        send_item(mk(MODE_BEGIN, 4'd0, 4'd0, 4'd0));
        send_item(mk(MODE_UNKNOWN, 4'd15, 4'd15, 4'd15));
        send_item(mk(MODE_STEP, 4'd0, 4'd3, 4'd0));
        drain_results();
        // empty string: a start state accepts right after begin
        set_config(5'd4, 5'd3, 16'h0003, 16'h0002);
        send_item(mk(MODE_BEGIN, 4'd0, 4'd0, 4'd0));
        drain_results();
        // shrink the state count below transitions already loaded
        set_config(5'd2, 5'd3, 16'h0003, 16'h0002);
        send_item(mk(MODE_BEGIN, 4'd0, 4'd0, 4'd0));
        send_item(mk(MODE_STEP, 4'd0, 4'd0, 4'd0));
        drain_results();
    endtask

    task automatic run_phase(input int ph);
        logic [4:0]  sc;
        logic [4:0]  asz;
        logic [15:0] st;
        logic [15:0] ac;
        int          ns;
        int          na;
        int          target;
        int          sent;
        int          r;
        int          len;
        bit          paused;
        logic [3:0]  sym;
        st = 16'($urandom);
        ac = 16'($urandom) & 16'($urandom);
        case (ph)
            0: begin sc = 5'd16; asz = 5'd16; end
            1: begin sc = 5'd1;  asz = 5'd1;  end
            2: begin sc = 5'd0;  asz = 5'($urandom_range(1, 16)); end
            3: begin sc = 5'd31; asz = 5'd31; st = 16'hFFFF; ac = 16'hFFFF; end
            4: begin sc = 5'd4;  asz = 5'd2;  end
            5: begin sc = 5'd3;  asz = 5'd16; ac = 16'h0000; end
            default: begin
                sc  = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(2, 16));
                asz = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
            end
        endcase
        set_config(sc, asz, st, ac);
        ns     = (sc > STATES) ? STATES : int'(sc);
        na     = (asz > SYMBOLS) ? SYMBOLS : int'(asz);
        target = (ns == 0 || na == 0) ? 20 : 80;
        sent   = 0;
        paused = 1'b0;
        while (sent < target) begin
            r         = $urandom_range(0, 99);
            tx_steady = ($urandom_range(0, 7) == 0);
            if (r < 15) begin
                repeat ($urandom_range(1, 4)) begin
                    send_item(mk(MODE_LOAD, pick_below(ns), pick_below(na), pick_below(ns)));
                    sent++;
                end
            end else if (r < 82) begin
                send_item(mk(MODE_BEGIN, 4'($urandom), 4'($urandom), 4'($urandom)));
                sent++;
                len = $urandom_range(0, 8);
                repeat (len) begin
                    sym = ($urandom_range(0, 9) == 0) ? 4'($urandom) : pick_below(na);
                    send_item(mk(MODE_STEP, 4'($urandom), sym, 4'($urandom)));
                    sent++;
                end
            end else begin
                send_item(t_item'(ITEM_W'($urandom)));
                sent++;
            end
            // hold the sender until everything outstanding has come back
            if (ph == 4 && !paused && sent >= target / 2) begin
                drain_results();
                paused = 1'b1;
            end
        end
        tx_steady = 1'b0;
        drain_results();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        for (int ph = 0; ph < 8; ph++) run_phase(ph);
        repeat (TAIL) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #(12 * LIMIT_CYCLES);
        $display("timeout with %0d results outstanding", sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
